// ===== design/mchs_pkg.sv =====
// ----------------------------------------------------------------------------
// mchs_pkg: shared definitions for the heartbeat supervisor
// Command codes, client count, timeout reset value and word layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package mchs_pkg;

  localparam int CLIENT_COUNT = 8;   // supported range 1 to 16

  localparam int TICK_W    = 32;
  localparam int TIMEOUT_W = 16;
  localparam int CMD_W     = 3;
  localparam int CLIENT_W  = 4;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;

  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INIT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NOTIFY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FEED   = 3'd4;

  // Client count as a value comparable with a client id (one bit wider).
  localparam logic [CLIENT_W:0] CLIENT_LIMIT = (CLIENT_W + 1)'(CLIENT_COUNT);

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  typedef logic [CLIENT_COUNT-1:0][TICK_W-1:0] hb_vec_t;

  // First field in the highest bits.
  typedef struct packed {
    logic [CLIENT_W-1:0] client;
    logic [CMD_W-1:0]    cmd;
  } in_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] last_feed_time;
    logic              is_initialized;
    logic              clients_alive;
    logic              fed;
  } result_t;

  // Input register contents handed to the core.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

`default_nettype wire

// ===== design/mchs_in_stage.sv =====
// ----------------------------------------------------------------------------
// mchs_in_stage: input word register
// Holds one accepted command word until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mchs_in_stage import mchs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  input  wire in_item_t s_item,
  output logic          s_tready,
  input  wire logic     take,
  output stage_t        stage
);

  logic     valid;
  in_item_t item;

  // Accept whenever the register is empty or being drained this cycle.
  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

`default_nettype wire

// ===== design/mchs_age_check.sv =====
// ----------------------------------------------------------------------------
// mchs_age_check: parallel heartbeat age comparison
// Flags whether every client's wrap-safe age is within the timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module mchs_age_check import mchs_pkg::*; (
  input  wire logic [TICK_W-1:0]    now_ticks,
  input  wire hb_vec_t              heartbeat_times,
  input  wire logic [TIMEOUT_W-1:0] timeout_ms,
  output logic                      all_ok
);

  logic [CLIENT_COUNT-1:0] late;

  always_comb begin
    for (int i = 0; i < CLIENT_COUNT; i++) begin
      late[i] = (now_ticks - heartbeat_times[i]) >
                {{(TICK_W-TIMEOUT_W){1'b0}}, timeout_ms};
    end
  end

  assign all_ok = ~|late;

endmodule

`default_nettype wire

// ===== design/mchs_core.sv =====
// ----------------------------------------------------------------------------
// mchs_core: supervisor state and result register
// Apply one command per cycle to tick, stamp and feed state unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module mchs_core import mchs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [TIMEOUT_W-1:0] cfg_data,
  input  wire stage_t               stage,
  output logic                      take,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output result_t                   m_result
);

  logic [TIMEOUT_W-1:0] timeout_ms;
  logic [TICK_W-1:0]    now_ticks, now_ticks_next;
  hb_vec_t              heartbeat_times, heartbeat_times_next;
  logic                 started, started_next;
  logic [TICK_W-1:0]    feed_time, feed_time_next;
  logic                 all_ok;
  result_t              result_next;

  mchs_age_check u_age (
    .now_ticks       (now_ticks),
    .heartbeat_times (heartbeat_times),
    .timeout_ms      (timeout_ms),
    .all_ok          (all_ok)
  );

  // Advance when a word waits and the result slot is free or draining.
  assign take = stage.valid && (!m_tvalid || m_tready);

  always_comb begin
    now_ticks_next       = now_ticks;
    heartbeat_times_next = heartbeat_times;
    started_next         = started;
    feed_time_next       = feed_time;
    result_next.fed           = 1'b0;
    result_next.clients_alive = 1'b0;
    case (stage.item.cmd)
      CMD_TICK: begin
        now_ticks_next = now_ticks + 1'b1;
      end
      CMD_INIT: begin
        if (!started) begin
          for (int i = 0; i < CLIENT_COUNT; i++) begin
            heartbeat_times_next[i] = now_ticks;
          end
          feed_time_next  = now_ticks;
          started_next    = 1'b1;
          result_next.fed = 1'b1;
        end
      end
      CMD_NOTIFY: begin
        if ({1'b0, stage.item.client} < CLIENT_LIMIT) begin
          for (int i = 0; i < CLIENT_COUNT; i++) begin
            if ({1'b0, stage.item.client} == (CLIENT_W + 1)'(i)) begin
              heartbeat_times_next[i] = now_ticks;
            end
          end
        end
      end
      CMD_CHECK: begin
        if (started && all_ok) begin
          result_next.fed           = 1'b1;
          result_next.clients_alive = 1'b1;
          feed_time_next            = now_ticks;
        end
      end
      CMD_FEED: begin
        if (started) begin
          result_next.fed = 1'b1;
          feed_time_next  = now_ticks;
        end
      end
      default: begin
      end
    endcase
    result_next.is_initialized = started_next;
    result_next.last_feed_time = feed_time_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ms <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks       <= '0;
      heartbeat_times <= '0;
      started         <= 1'b0;
      feed_time       <= '0;
    end else if (take) begin
      now_ticks       <= now_ticks_next;
      heartbeat_times <= heartbeat_times_next;
      started         <= started_next;
      feed_time       <= feed_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_result <= result_next;
    end
  end

  a_alive_feeds : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_result.clients_alive |-> m_result.fed)
    else $error("clients alive reported without a feed");

  a_feed_stamps_now : assert property (@(posedge clk) disable iff (rst)
    take && result_next.fed |=> m_result.last_feed_time == $past(now_ticks))
    else $error("feed did not record the current tick");

  a_started_sticks : assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("initialized flag dropped");

  a_tick_advances : assert property (@(posedge clk) disable iff (rst)
    take && stage.item.cmd == CMD_TICK |=> now_ticks == $past(now_ticks) + 1'b1)
    else $error("tick did not advance the counter");

endmodule

`default_nettype wire

// ===== design/multi_client_heartbeat_supervisor.sv =====
// ----------------------------------------------------------------------------
// multi_client_heartbeat_supervisor: watchdog manager for several clients
// Keeps a tick counter and a heartbeat stamp per client; feeds on command.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream carries one command word per handshake: tick, init, notify
//   a client, check and feed, or direct feed. Every word yields exactly one
//   result word on the master stream: fed pulse, all-alive flag,
//   initialized flag and the tick count of the most recent feed.
//   cfg_we/cfg_data write the 16-bit timeout (largest allowed heartbeat age
//   in ticks); write it only while no word is in flight. Reset value 5000.
//   An accepted word enters the input register, and its result is then
//   registered in the result register, from which the master side takes
//   it. Throughput: one word per cycle while m_tready keeps the result
//   stream draining, set by the single pass through the eight parallel
//   age compares between the two registers.
//   Reset (rst, synchronous): counter, stamps and feed time clear to zero,
//   not initialized, both stages empty, timeout back to 5000.
//   Stall: while a result waits on m_tready one further word is still taken
//   into the input register; after that s_tready drops until the result
//   drains. No word is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_client_heartbeat_supervisor import mchs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // timeout_ms register
  input  wire logic                  cfg_we,
  input  wire logic [TIMEOUT_W-1:0]  cfg_data,
  // command stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [2:0] cmd, [6:3] client, [7] zero
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata    // [0] fed, [1] clients_alive,
                                                // [2] is_initialized,
                                                // [34:3] last_feed_time, rest zero
);

  in_item_t s_item;
  stage_t   stage;
  logic     take;
  result_t  m_result;

  // Unpack the command word; the pad bit is dropped.
  assign s_item = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);

  // Hold one command word until the core is free to take it.
  mchs_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_item   (s_item),
    .s_tready (s_tready),
    .take     (take),
    .stage    (stage)
  );

  // Apply the command to the supervisor state and register the result.
  mchs_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .stage    (stage),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (m_result)
  );

  // Pad the result word up to whole bytes.
  assign m_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, m_result};

endmodule

`default_nettype wire
